@@ hw/rtl/blq_pkg.sv @@
`default_nettype none

package blq_pkg;

  // field and register widths
  localparam int THRESH_W  = 12;
  localparam int WINDOW_W  = 8;
  localparam int CONFIRM_W = 4;
  localparam int COUNT_W   = 4;
  localparam int LEVEL_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = THRESH_W;

  localparam int SAMPLE_BITS_DEF = 12;

  // stability bounds come out of reset at 1000, which needs 10 bits
  localparam int BOUND_RESET   = 1000;
  localparam int BOUND_RESET_W = 10;

  // register reset values
  localparam logic [THRESH_W-1:0]  THRESH_HIGH_RST = 12'd4000;
  localparam logic [THRESH_W-1:0]  THRESH_FULL_RST = 12'd3328;
  localparam logic [THRESH_W-1:0]  THRESH_TWO_RST  = 12'd3157;
  localparam logic [THRESH_W-1:0]  THRESH_ONE_RST  = 12'd2987;
  localparam logic [THRESH_W-1:0]  THRESH_ZERO_RST = 12'd2645;
  localparam logic [WINDOW_W-1:0]  WINDOW_RST      = 8'd32;
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST     = 4'd9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FULL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_ZERO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 3'd6;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_EMPTY = 3'd0,
    LVL_LV0   = 3'd1,
    LVL_LV1   = 3'd2,
    LVL_LV2   = 3'd3,
    LVL_FULL  = 3'd4,
    LVL_HIGH  = 3'd5
  } level_t;

endpackage

`default_nettype wire

@@ hw/rtl/battery_level_qualifier_top.sv @@
// Path: an input beat passes the input register, then the result register, to
//   its result beat; a stalled output side holds it there and stalls the input.
// Throughput: one sample per cycle unless the output stalls; the level/bound
//   update is a single pass of compares and one add/subtract between stages.
// Reset (rst, synchronous, active high): both stages empty, thresholds and
//   window/confirm registers at defaults, bounds at 1000, count 0, level full.
`default_nettype none

module battery_level_qualifier_top
  import blq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,

  // configuration write port
  input  wire logic                                wr_en,
  input  wire logic [CFG_IDX_W-1:0]                wr_index,
  input  wire logic [CFG_DATA_W-1:0]               wr_data,

  // sample stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample
  input  wire logic [1:0]                          s_axis_tuser,  // sys_ready, charging

  // level stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [7:0]                               m_axis_tdata,  // level, zero pad
  output logic                                     m_axis_tuser   // evaluated
);

  // bound widths: wide enough for sample + window and for the reset value
  localparam int UB_W  = (SAMPLE_BITS + 1 > BOUND_RESET_W) ? SAMPLE_BITS + 1 : BOUND_RESET_W;
  localparam int LB_W  = (SAMPLE_BITS > BOUND_RESET_W) ? SAMPLE_BITS : BOUND_RESET_W;
  localparam int CMP_W = (UB_W > THRESH_W) ? UB_W : THRESH_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [THRESH_W-1:0]  thresh_high;
  logic [THRESH_W-1:0]  thresh_full;
  logic [THRESH_W-1:0]  thresh_two;
  logic [THRESH_W-1:0]  thresh_one;
  logic [THRESH_W-1:0]  thresh_zero;
  logic [WINDOW_W-1:0]  stable_window;
  logic [CONFIRM_W-1:0] confirm_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_high   <= THRESH_HIGH_RST;
      thresh_full   <= THRESH_FULL_RST;
      thresh_two    <= THRESH_TWO_RST;
      thresh_one    <= THRESH_ONE_RST;
      thresh_zero   <= THRESH_ZERO_RST;
      stable_window <= WINDOW_RST;
      confirm_count <= CONFIRM_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_THRESH_HIGH: thresh_high   <= wr_data;
        REG_THRESH_FULL: thresh_full   <= wr_data;
        REG_THRESH_TWO:  thresh_two    <= wr_data;
        REG_THRESH_ONE:  thresh_one    <= wr_data;
        REG_THRESH_ZERO: thresh_zero   <= wr_data;
        REG_WINDOW:      stable_window <= wr_data[WINDOW_W-1:0];
        REG_CONFIRM:     confirm_count <= wr_data[CONFIRM_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   sys_ready;
  logic                   charging;
  logic                   advance;

  // stage 1 moves into the result register when that is empty or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample    <= s_axis_tdata[SAMPLE_BITS-1:0];
      sys_ready <= s_axis_tuser[0];
      charging  <= s_axis_tuser[1];
    end
  end

  // ---------------------------------------------------------------------------
  // classification
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] s_ext;
  logic ge_high, ge_full, ge_two, ge_one, ge_zero;

  assign s_ext   = CMP_W'(sample);
  assign ge_high = s_ext >= CMP_W'(thresh_high);
  assign ge_full = s_ext >= CMP_W'(thresh_full);
  assign ge_two  = s_ext >= CMP_W'(thresh_two);
  assign ge_one  = s_ext >= CMP_W'(thresh_one);
  assign ge_zero = s_ext >= CMP_W'(thresh_zero);

  level_t battery_level;
  level_t battery_level_next;
  level_t lvl_direct;
  level_t lvl_rising;
  level_t lvl_falling;

  // thresholds are checked top down in fixed order, no reordering
  always_comb begin
    if (ge_high)      lvl_direct = LVL_HIGH;
    else if (ge_full) lvl_direct = LVL_FULL;
    else if (ge_two)  lvl_direct = LVL_LV2;
    else if (ge_one)  lvl_direct = LVL_LV1;
    else if (ge_zero) lvl_direct = LVL_LV0;
    else              lvl_direct = LVL_EMPTY;
  end

  // charging: high/full direct, lv2/lv1 only from at or below, else lv0
  always_comb begin
    if (ge_high)                                lvl_rising = LVL_HIGH;
    else if (ge_full)                           lvl_rising = LVL_FULL;
    else if (ge_two && battery_level <= LVL_LV2) lvl_rising = LVL_LV2;
    else if (ge_one && battery_level <= LVL_LV1) lvl_rising = LVL_LV1;
    else                                        lvl_rising = LVL_LV0;
  end

  // discharging: high direct, lower steps only from at or above, else empty
  always_comb begin
    if (ge_high)                                  lvl_falling = LVL_HIGH;
    else if (ge_full && battery_level >= LVL_FULL) lvl_falling = LVL_FULL;
    else if (ge_two && battery_level >= LVL_LV2)   lvl_falling = LVL_LV2;
    else if (ge_one && battery_level >= LVL_LV1)   lvl_falling = LVL_LV1;
    else if (ge_zero && battery_level >= LVL_LV0)  lvl_falling = LVL_LV0;
    else                                          lvl_falling = LVL_EMPTY;
  end

  // ---------------------------------------------------------------------------
  // stability window and confirm counter
  // ---------------------------------------------------------------------------
  logic [UB_W-1:0]        upper_bound;
  logic [UB_W-1:0]        upper_bound_next;
  logic [LB_W-1:0]        lower_bound;
  logic [LB_W-1:0]        lower_bound_next;
  logic [COUNT_W-1:0]     stable_count;
  logic [COUNT_W-1:0]     stable_count_next;
  logic [SAMPLE_BITS:0]   upper_sum;
  logic [SAMPLE_BITS-1:0] win_ext;
  logic                   in_window;
  logic                   evaluated_next;

  assign win_ext   = SAMPLE_BITS'(stable_window);
  assign upper_sum = (SAMPLE_BITS + 1)'(sample) + (SAMPLE_BITS + 1)'(stable_window);
  assign upper_bound_next = UB_W'(upper_sum);
  // clamp at zero when the window reaches below the sample
  assign lower_bound_next = (sample >= win_ext) ? LB_W'(sample - win_ext) : '0;

  // strictly between the bounds of the last sample taken while sys_ready
  assign in_window = (s_ext < CMP_W'(upper_bound)) && (s_ext > CMP_W'(lower_bound));

  always_comb begin
    battery_level_next = battery_level;
    stable_count_next  = stable_count;
    evaluated_next     = 1'b0;
    if (!sys_ready) begin
      battery_level_next = lvl_direct;
      evaluated_next     = 1'b1;
    end else if (!in_window) begin
      stable_count_next = '0;
    end else if (stable_count < confirm_count) begin
      stable_count_next = stable_count + 1'b1;
    end else begin
      // confirmed: count holds, every further stable sample reevaluates
      battery_level_next = charging ? lvl_rising : lvl_falling;
      evaluated_next     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_bound   <= UB_W'(BOUND_RESET);
      lower_bound   <= LB_W'(BOUND_RESET);
      stable_count  <= '0;
      battery_level <= LVL_FULL;
    end else if (advance) begin
      battery_level <= battery_level_next;
      stable_count  <= stable_count_next;
      // bounds only move once the system is ready
      if (sys_ready) begin
        upper_bound <= upper_bound_next;
        lower_bound <= lower_bound_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {{(8 - LEVEL_W){1'b0}}, battery_level_next};
      m_axis_tuser <= evaluated_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/blq_checker.sv @@
`default_nettype none

module blq_checker
  import blq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tuser
);

  // output side empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat valid after reset");

  // a pending result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // payload of a stalled result beat does not move
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // input stalls only because the output is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with output free");

  // level is always one of the six steps, upper pad bits are zero
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[LEVEL_W-1:0] <= LVL_HIGH && m_axis_tdata[7:LEVEL_W] == '0)
    else $error("level out of range");

endmodule

bind battery_level_qualifier_top blq_checker u_blq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
